@@ rtl/gss_pkg.sv @@
package gss_pkg;

    // Position words are two's complement, fixed width; the fraction point does not
    // change any decision because all arithmetic is done on raw words.
    localparam int POSITION_BITS      = 32;
    localparam int VALUE_BITS_DEFAULT = 32;
    localparam int CFG_INDEX_BITS     = 2;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_BITS-1:0] REG_LOWER_BOUND = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_UPPER_BOUND = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_TOLERANCE   = 2'd2;

    // Configuration reset values.
    localparam logic [POSITION_BITS-1:0] LOWER_BOUND_RESET = 32'd0;
    localparam logic [POSITION_BITS-1:0] UPPER_BOUND_RESET = 32'd65536;
    localparam logic [POSITION_BITS-1:0] TOLERANCE_RESET   = 32'd66;

    // Input item kinds.
    localparam logic KIND_START = 1'b0;
    localparam logic KIND_VALUE = 1'b1;

    // Golden ratio factors in Q0.32: 1/phi and 1/phi^2, which sum to one.
    localparam logic [31:0] INV_PHI_Q32  = 32'd2654435769;
    localparam logic [31:0] INV_PHI2_Q32 = 32'd1640531527;

    // Search phase.
    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_FIRST = 2'd1,
        PH_HIGH  = 2'd2,
        PH_LOW   = 2'd3
    } phase_t;

    // One result item.
    typedef struct packed {
        logic [POSITION_BITS-1:0] probe_point;
        logic [POSITION_BITS-1:0] interval_low;
        logic [POSITION_BITS-1:0] interval_high;
        logic                     finished;
        logic                     out_of_order;
    } result_t;

    // Unsigned width times a Q0.32 factor, rounded to nearest.
    function automatic logic [POSITION_BITS-1:0] scale(
        input logic [POSITION_BITS-1:0] w,
        input logic [31:0]              k
    );
        logic [63:0] prod;
        begin
            prod = 64'(w) * 64'(k) + 64'h0000_0000_8000_0000;
            return prod[63:32];
        end
    endfunction

endpackage

@@ rtl/gss_skid.sv @@
module gss_skid (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  gss_pkg::result_t  push_item,
    output logic              full,
    output logic              pop_valid,
    input  logic              pop_stall,
    output gss_pkg::result_t  pop_item
);

    logic             main_valid_reg;
    logic             skid_valid_reg;
    gss_pkg::result_t main_item_reg;
    gss_pkg::result_t skid_item_reg;
    logic             pop;

    assign pop       = main_valid_reg && !pop_stall;
    assign full      = skid_valid_reg;
    assign pop_valid = main_valid_reg;
    assign pop_item  = main_item_reg;

    // Valid flags: the skid entry fills only when the main entry is held.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (pop)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (push)
        begin
            if (main_valid_reg && !pop)
            begin
                skid_valid_reg <= 1'b1;
            end
            else
            begin
                main_valid_reg <= 1'b1;
            end
        end
        else if (pop)
        begin
            main_valid_reg <= 1'b0;
        end
    end

    // Payload moves without reset.
    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                main_item_reg <= skid_item_reg;
            end
        end
        else if (push)
        begin
            if (main_valid_reg && !pop)
            begin
                skid_item_reg <= push_item;
            end
            else
            begin
                main_item_reg <= push_item;
            end
        end
    end

endmodule

@@ rtl/golden_section_search_core.sv @@
// A result item is registered in the output buffer when its input item is accepted.
// Throughput: one item per cycle while item_stall is low; each item passes two 32x32
// constant multipliers and one add between the state registers and the result register.
// A two-entry output buffer keeps items flowing while the result side stalls.
// Reset (rst_n, asynchronous, active low) returns the search to idle and loads the
// bound and tolerance registers with their defaults; no clearing pass is needed.
module golden_section_search_core #(
    parameter int VALUE_BITS = gss_pkg::VALUE_BITS_DEFAULT
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    item_valid,
    output logic                                    item_stall,
    input  logic                                    kind,
    input  logic signed [VALUE_BITS-1:0]            function_value,
    output logic                                    result_valid,
    input  logic                                    result_stall,
    output logic signed [gss_pkg::POSITION_BITS-1:0] probe_point,
    output logic signed [gss_pkg::POSITION_BITS-1:0] interval_low,
    output logic signed [gss_pkg::POSITION_BITS-1:0] interval_high,
    output logic                                    finished,
    output logic                                    out_of_order,
    input  logic                                    cfg_valid,
    output logic                                    cfg_ready,
    input  logic [gss_pkg::CFG_INDEX_BITS-1:0]      cfg_index,
    input  logic [gss_pkg::POSITION_BITS-1:0]       cfg_data
);

    localparam int PB = gss_pkg::POSITION_BITS;

    // Configuration registers, with the ordered bounds and span kept ready.
    logic [PB-1:0] lower_reg, upper_reg, tol_reg;
    logic [PB-1:0] ord_lo_reg, ord_hi_reg, span_reg;
    logic [PB-1:0] cfg_lower, cfg_upper, cfg_lo, cfg_hi;
    logic          cfg_write;

    // Search state.
    logic [PB-1:0]         left_reg, right_reg, inner_low_reg, inner_high_reg;
    logic [PB-1:0]         left_next, right_next, inner_low_next, inner_high_next;
    logic [VALUE_BITS-1:0] value_low_reg, value_high_reg, value_low_next, value_high_next;
    logic [PB-1:0]         width_reg, shrunk_reg, width_next, shrunk_next;
    gss_pkg::phase_t       phase_reg, phase_next;

    // Datapath signals.
    logic                  accept;
    logic                  narrow, stop, low_wins;
    logic [VALUE_BITS-1:0] cmp_low, cmp_high;
    logic [PB-1:0]         mul_in, prod_long, prod_short;
    gss_pkg::result_t      result;
    gss_pkg::result_t      out_item;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;
    assign accept    = item_valid && !item_stall;

    // Order the bounds as they are written, so a start needs no compare of its own.
    always_comb
    begin
        cfg_lower = (cfg_index == gss_pkg::REG_LOWER_BOUND) ? cfg_data : lower_reg;
        cfg_upper = (cfg_index == gss_pkg::REG_UPPER_BOUND) ? cfg_data : upper_reg;
        if ($signed(cfg_upper) < $signed(cfg_lower))
        begin
            cfg_lo = cfg_upper;
            cfg_hi = cfg_lower;
        end
        else
        begin
            cfg_lo = cfg_lower;
            cfg_hi = cfg_upper;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lower_reg  <= gss_pkg::LOWER_BOUND_RESET;
            upper_reg  <= gss_pkg::UPPER_BOUND_RESET;
            tol_reg    <= gss_pkg::TOLERANCE_RESET;
            ord_lo_reg <= gss_pkg::LOWER_BOUND_RESET;
            ord_hi_reg <= gss_pkg::UPPER_BOUND_RESET;
            span_reg   <= gss_pkg::UPPER_BOUND_RESET - gss_pkg::LOWER_BOUND_RESET;
        end
        else if (cfg_write)
        begin
            lower_reg  <= cfg_lower;
            upper_reg  <= cfg_upper;
            ord_lo_reg <= cfg_lo;
            ord_hi_reg <= cfg_hi;
            span_reg   <= cfg_hi - cfg_lo;
            if (cfg_index == gss_pkg::REG_TOLERANCE)
            begin
                tol_reg <= cfg_data;
            end
        end
    end

    // Shared multipliers: the start scales the span, a decision scales the shrunk width.
    assign mul_in     = (kind == gss_pkg::KIND_START) ? span_reg : shrunk_reg;
    assign prod_long  = gss_pkg::scale(mul_in, gss_pkg::INV_PHI_Q32);
    assign prod_short = gss_pkg::scale(mul_in, gss_pkg::INV_PHI2_Q32);

    // Decision terms. A tie keeps the upper side.
    assign cmp_low  = (phase_reg == gss_pkg::PH_LOW)  ? function_value : value_low_reg;
    assign cmp_high = (phase_reg == gss_pkg::PH_HIGH) ? function_value : value_high_reg;
    assign low_wins = $signed(cmp_low) < $signed(cmp_high);
    assign narrow   = span_reg < tol_reg;
    assign stop     = (shrunk_reg <= tol_reg) || (shrunk_reg >= width_reg);

    // Next phase.
    always_comb
    begin
        phase_next = phase_reg;
        if (accept)
        begin
            if (kind == gss_pkg::KIND_START)
            begin
                if (narrow)
                begin
                    phase_next = gss_pkg::PH_IDLE;
                end
                else
                begin
                    phase_next = gss_pkg::PH_FIRST;
                end
            end
            else
            begin
                case (phase_reg)
                    gss_pkg::PH_FIRST:
                    begin
                        phase_next = gss_pkg::PH_HIGH;
                    end
                    gss_pkg::PH_HIGH, gss_pkg::PH_LOW:
                    begin
                        if (stop)
                        begin
                            phase_next = gss_pkg::PH_IDLE;
                        end
                        else if (low_wins)
                        begin
                            phase_next = gss_pkg::PH_LOW;
                        end
                        else
                        begin
                            phase_next = gss_pkg::PH_HIGH;
                        end
                    end
                    default:
                    begin
                        phase_next = gss_pkg::PH_IDLE;
                    end
                endcase
            end
        end
    end

    // Bracket update and result item.
    always_comb
    begin
        left_next       = left_reg;
        right_next      = right_reg;
        inner_low_next  = inner_low_reg;
        inner_high_next = inner_high_reg;
        value_low_next  = value_low_reg;
        value_high_next = value_high_reg;
        width_next      = width_reg;
        shrunk_next     = shrunk_reg;
        result          = '0;
        if (kind == gss_pkg::KIND_START)
        begin
            if (narrow)
            begin
                result.interval_low  = ord_lo_reg;
                result.interval_high = ord_hi_reg;
                result.finished      = 1'b1;
            end
            else
            begin
                left_next          = ord_lo_reg;
                right_next         = ord_hi_reg;
                width_next         = span_reg;
                shrunk_next        = prod_long;
                inner_low_next     = ord_lo_reg + prod_short;
                inner_high_next    = ord_lo_reg + prod_long;
                result.probe_point = inner_low_next;
            end
        end
        else
        begin
            case (phase_reg)
                gss_pkg::PH_FIRST:
                begin
                    value_low_next     = function_value;
                    result.probe_point = inner_high_reg;
                end
                gss_pkg::PH_HIGH, gss_pkg::PH_LOW:
                begin
                    value_low_next  = cmp_low;
                    value_high_next = cmp_high;
                    if (stop)
                    begin
                        result.finished      = 1'b1;
                        result.interval_low  = low_wins ? left_reg : inner_low_reg;
                        result.interval_high = low_wins ? inner_high_reg : right_reg;
                    end
                    else
                    begin
                        width_next  = shrunk_reg;
                        shrunk_next = prod_long;
                        if (low_wins)
                        begin
                            // Keep the lower side; the old low probe becomes the high one.
                            right_next         = inner_high_reg;
                            inner_high_next    = inner_low_reg;
                            value_high_next    = cmp_low;
                            inner_low_next     = left_reg + prod_short;
                            result.probe_point = inner_low_next;
                        end
                        else
                        begin
                            // Keep the upper side; the old high probe becomes the low one.
                            left_next          = inner_low_reg;
                            inner_low_next     = inner_high_reg;
                            value_low_next     = cmp_high;
                            inner_high_next    = inner_low_reg + prod_long;
                            result.probe_point = inner_high_next;
                        end
                    end
                end
                default:
                begin
                    result.out_of_order = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= gss_pkg::PH_IDLE;
        end
        else
        begin
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            left_reg       <= left_next;
            right_reg      <= right_next;
            inner_low_reg  <= inner_low_next;
            inner_high_reg <= inner_high_next;
            value_low_reg  <= value_low_next;
            value_high_reg <= value_high_next;
            width_reg      <= width_next;
            shrunk_reg     <= shrunk_next;
        end
    end

    // Result buffer between the search logic and the result channel.
    gss_skid u_skid (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .push_item (result),
        .full      (item_stall),
        .pop_valid (result_valid),
        .pop_stall (result_stall),
        .pop_item  (out_item)
    );

    assign probe_point   = out_item.probe_point;
    assign interval_low  = out_item.interval_low;
    assign interval_high = out_item.interval_high;
    assign finished      = out_item.finished;
    assign out_of_order  = out_item.out_of_order;

endmodule

@@ tb/gss_search_checker.sv @@
`timescale 1ns / 1ps

// Watches the item, result and configuration channels of the search core.
// Keeps its own copy of the bound registers and the search state, predicts one
// result item per accepted input item, and compares results in order.
module gss_search_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    input  logic        item_stall,
    input  logic        kind,
    input  logic [31:0] function_value,
    input  logic        result_valid,
    input  logic        result_stall,
    input  logic [31:0] probe_point,
    input  logic [31:0] interval_low,
    input  logic [31:0] interval_high,
    input  logic        finished,
    input  logic        out_of_order,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    output int          failures,
    output int          pending
);

    // Golden ratio factors in Q0.32.
    localparam logic [31:0] RECIP_PHI    = 32'd2654435769;
    localparam logic [31:0] RECIP_PHI_SQ = 32'd1640531527;

    // Register copies.
    logic [31:0] lower_reg;
    logic [31:0] upper_reg;
    logic [31:0] tol_reg;

    // Search state.
    logic [31:0]     seg_left;
    logic [31:0]     seg_right;
    logic [31:0]     probe_low;
    logic [31:0]     probe_high;
    logic [31:0]     fval_low;
    logic [31:0]     fval_high;
    logic [31:0]     span;
    gss_pkg::phase_t search_phase;

    gss_pkg::result_t expected_results[$];
    int               err_count = 0;
    int               pending_count = 0;

    assign failures = err_count;
    assign pending  = pending_count;

    // Unsigned width times a Q0.32 factor, rounded to nearest.
    function automatic logic [31:0] golden_scale(input logic [31:0] w, input logic [31:0] k);
        logic [63:0] prod;
        prod = {32'd0, w} * {32'd0, k};
        return prod[63:32] + {31'd0, prod[31]};
    endfunction

    // Keep the better side after both inner values are known, then either
    // request the next probe point or give the final bracket.
    function automatic gss_pkg::result_t narrow_bracket();
        gss_pkg::result_t r;
        logic             low_better;
        logic [31:0]      next_span;
        r = '0;
        low_better = $signed(fval_low) < $signed(fval_high);
        next_span = golden_scale(span, RECIP_PHI);
        if (next_span <= tol_reg || next_span >= span)
        begin
            search_phase = gss_pkg::PH_IDLE;
            r.finished = 1'b1;
            if (low_better)
            begin
                r.interval_low  = seg_left;
                r.interval_high = probe_high;
            end
            else
            begin
                r.interval_low  = probe_low;
                r.interval_high = seg_right;
            end
        end
        else
        begin
            span = next_span;
            if (low_better)
            begin
                seg_right    = probe_high;
                probe_high   = probe_low;
                fval_high    = fval_low;
                probe_low    = seg_left + golden_scale(next_span, RECIP_PHI_SQ);
                search_phase = gss_pkg::PH_LOW;
                r.probe_point = probe_low;
            end
            else
            begin
                seg_left     = probe_low;
                probe_low    = probe_high;
                fval_low     = fval_high;
                probe_high   = seg_left + golden_scale(next_span, RECIP_PHI);
                search_phase = gss_pkg::PH_HIGH;
                r.probe_point = probe_high;
            end
        end
        return r;
    endfunction

    // Expected result of one input item; updates the search state.
    function automatic gss_pkg::result_t predict_item(input logic item_kind,
                                                      input logic [31:0] fv);
        gss_pkg::result_t r;
        logic [31:0]      a;
        logic [31:0]      b;
        logic [31:0]      w;
        r = '0;
        if (item_kind == gss_pkg::KIND_START)
        begin
            a = lower_reg;
            b = upper_reg;
            if ($signed(upper_reg) < $signed(lower_reg))
            begin
                a = upper_reg;
                b = lower_reg;
            end
            w = b - a;
            if (w < tol_reg)
            begin
                // The interval is already narrow enough.
                search_phase = gss_pkg::PH_IDLE;
                r.interval_low  = a;
                r.interval_high = b;
                r.finished      = 1'b1;
            end
            else
            begin
                seg_left     = a;
                seg_right    = b;
                span         = w;
                probe_low    = a + golden_scale(w, RECIP_PHI_SQ);
                probe_high   = a + golden_scale(w, RECIP_PHI);
                search_phase = gss_pkg::PH_FIRST;
                r.probe_point = probe_low;
            end
        end
        else
        begin
            case (search_phase)
                gss_pkg::PH_FIRST:
                begin
                    fval_low = fv;
                    search_phase = gss_pkg::PH_HIGH;
                    r.probe_point = probe_high;
                end
                gss_pkg::PH_HIGH:
                begin
                    fval_high = fv;
                    r = narrow_bracket();
                end
                gss_pkg::PH_LOW:
                begin
                    fval_low = fv;
                    r = narrow_bracket();
                end
                default: r.out_of_order = 1'b1;
            endcase
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        err_count++;
        $display("%0t ns: %s mismatch: got %h, expected %h", $time, what, got, want);
    endtask

    // Results are checked before the item of the same edge is predicted, since
    // a result never leaves in the cycle its item is accepted.
    always @(posedge clk or negedge rst_n)
    begin : watch
        gss_pkg::result_t want;
        if (!rst_n)
        begin
            lower_reg    = gss_pkg::LOWER_BOUND_RESET;
            upper_reg    = gss_pkg::UPPER_BOUND_RESET;
            tol_reg      = gss_pkg::TOLERANCE_RESET;
            seg_left     = '0;
            seg_right    = '0;
            probe_low    = '0;
            probe_high   = '0;
            fval_low     = '0;
            fval_high    = '0;
            span         = '0;
            search_phase = gss_pkg::PH_IDLE;
            expected_results.delete();
        end
        else
        begin
            if (result_valid && !result_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    report_mismatch("unexpected result item", probe_point, 32'd0);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (probe_point !== want.probe_point)
                        report_mismatch("probe_point", probe_point, want.probe_point);
                    if (interval_low !== want.interval_low)
                        report_mismatch("interval_low", interval_low, want.interval_low);
                    if (interval_high !== want.interval_high)
                        report_mismatch("interval_high", interval_high, want.interval_high);
                    if (finished !== want.finished)
                        report_mismatch("finished", {31'd0, finished}, {31'd0, want.finished});
                    if (out_of_order !== want.out_of_order)
                        report_mismatch("out_of_order", {31'd0, out_of_order},
                                        {31'd0, want.out_of_order});
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    gss_pkg::REG_LOWER_BOUND: lower_reg = cfg_data;
                    gss_pkg::REG_UPPER_BOUND: upper_reg = cfg_data;
                    gss_pkg::REG_TOLERANCE:   tol_reg   = cfg_data;
                    default: ;
                endcase
            end
            if (item_valid && !item_stall)
                expected_results.insert(expected_results.size(),
                                        predict_item(kind, function_value));
        end
        pending_count = expected_results.size();
    end

endmodule

@@ tb/golden_section_search_core_tb.sv @@
`timescale 1ns / 1ps

// Drives start and value items into the search core, changes the bounds and the
// tolerance between phases, and gives the verdict from the checker's count.
module golden_section_search_core_tb;

    localparam logic [gss_pkg::CFG_INDEX_BITS-1:0] REG_SPARE = 2'd3;
    localparam int ITEM_TARGET = 1600;
    localparam int PHASE_ITEMS = 160;

    typedef enum int {
        FLOW_FREE,
        FLOW_RANDOM,
        FLOW_PERIODIC,
        FLOW_HEAVY
    } flow_mode_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        item_valid = 1'b0;
    logic        item_stall;
    logic        kind = gss_pkg::KIND_START;
    logic [31:0] function_value = '0;
    logic        result_valid;
    logic        result_stall = 1'b0;
    logic [31:0] probe_point;
    logic [31:0] interval_low;
    logic [31:0] interval_high;
    logic        finished;
    logic        out_of_order;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = gss_pkg::REG_LOWER_BOUND;
    logic [31:0] cfg_data = '0;

    int          failures;
    int          pending;
    int          items_sent = 0;
    int          burst_left = 0;
    logic [31:0] last_value = '0;

    // Bounds currently loaded, used only to size the searches.
    logic [31:0] cur_lo = gss_pkg::LOWER_BOUND_RESET;
    logic [31:0] cur_hi = gss_pkg::UPPER_BOUND_RESET;
    logic [31:0] cur_tol = gss_pkg::TOLERANCE_RESET;

    flow_mode_t  flow_mode = FLOW_FREE;
    int          flow_left = 0;
    int          flow_tick = 0;

    golden_section_search_core u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .item_valid     (item_valid),
        .item_stall     (item_stall),
        .kind           (kind),
        .function_value (function_value),
        .result_valid   (result_valid),
        .result_stall   (result_stall),
        .probe_point    (probe_point),
        .interval_low   (interval_low),
        .interval_high  (interval_high),
        .finished       (finished),
        .out_of_order   (out_of_order),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    gss_search_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .item_valid     (item_valid),
        .item_stall     (item_stall),
        .kind           (kind),
        .function_value (function_value),
        .result_valid   (result_valid),
        .result_stall   (result_stall),
        .probe_point    (probe_point),
        .interval_low   (interval_low),
        .interval_high  (interval_high),
        .finished       (finished),
        .out_of_order   (out_of_order),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .failures       (failures),
        .pending        (pending)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Hard stop in case the core hangs.
    initial
    begin
        #5_000_000;
        $display("golden_section_search_core_tb: FAIL");
        $finish;
    end

    // The result side stalls in modes that are picked at random: free, random, periodic, heavy.
    always @(negedge clk)
    begin
        if (flow_left == 0)
        begin
            flow_mode = flow_mode_t'($urandom_range(0, 3));
            flow_left = $urandom_range(40, 300);
        end
        flow_left--;
        flow_tick++;
        case (flow_mode)
            FLOW_FREE:     result_stall <= 1'b0;
            FLOW_RANDOM:   result_stall <= ($urandom_range(0, 99) < 35);
            FLOW_PERIODIC: result_stall <= ((flow_tick % 7) < 4);
            default:       result_stall <= ($urandom_range(0, 99) < 80);
        endcase
    end

    // Sends one item in bursts with random gaps; called and returns at a falling edge.
    task automatic send_item(input logic item_kind, input logic [31:0] value);
        int gap;
        gap = 0;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end
        burst_left--;
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        item_valid     <= 1'b1;
        kind           <= item_kind;
        function_value <= value;
        @(posedge clk);
        while (item_stall) @(posedge clk);
        items_sent++;
        @(negedge clk);
    endtask

    // Waits until every expected result has come, plus the output latency.
    task automatic drain();
        item_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (3) @(negedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    task automatic set_search(input logic [31:0] lo, input logic [31:0] hi,
                              input logic [31:0] tol);
        drain();
        write_reg(gss_pkg::REG_LOWER_BOUND, lo);
        write_reg(gss_pkg::REG_UPPER_BOUND, hi);
        write_reg(gss_pkg::REG_TOLERANCE, tol);
        cur_lo  = lo;
        cur_hi  = hi;
        cur_tol = tol;
    endtask

    // Width of the ordered interval for the loaded bounds.
    function automatic logic [31:0] loaded_width();
        if ($signed(cur_hi) < $signed(cur_lo))
            return cur_lo - cur_hi;
        return cur_hi - cur_lo;
    endfunction

    // Rough number of values a full search takes with the loaded setting.
    function automatic int search_length();
        logic [31:0] diff;
        real         w;
        int          n;
        diff = loaded_width();
        w = diff;
        if (diff < cur_tol)
            return 0;
        n = 2;
        while (w * 0.618034 > cur_tol && w >= 2.0 && n < 80)
        begin
            w = w * 0.618034;
            n++;
        end
        return n;
    endfunction

    // Function values: mostly random, with ties and the extremes mixed in.
    function automatic logic [31:0] pick_value();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll == 0)
            return last_value;
        if (roll == 1)
            last_value = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
        else
            last_value = $urandom();
        return last_value;
    endfunction

    // One search: usually run to the end, sometimes cut short by a restart,
    // sometimes followed by values that arrive with no search running.
    task automatic run_session();
        int n;
        int count;
        int roll;
        n = search_length();
        roll = $urandom_range(0, 9);
        if (roll < 7)
            count = n;
        else if (roll < 9)
            count = $urandom_range(0, n);
        else
            count = n + $urandom_range(1, 3);
        send_item(gss_pkg::KIND_START, $urandom());
        repeat (count) send_item(gss_pkg::KIND_VALUE, pick_value());
    endtask

    task automatic random_setting();
        logic [31:0] lo;
        logic [31:0] hi;
        logic [31:0] tol;
        lo = $urandom();
        hi = $urandom_range(0, 1) ? lo + $urandom_range(0, 1 << 20) : $urandom();
        if ($urandom_range(0, 1))
            {lo, hi} = {hi, lo};
        cur_lo = lo;
        cur_hi = hi;
        case ($urandom_range(0, 4))
            0: tol = 32'd0;
            1: tol = $urandom_range(0, 1000);
            2: tol = $urandom() >> $urandom_range(8, 31);
            3: tol = loaded_width();
            default: tol = gss_pkg::TOLERANCE_RESET;
        endcase
        set_search(lo, hi, tol);
    endtask

    initial
    begin : stimulus
        int phase_no;
        int phase_start;
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Values with no search running, at both extremes.
        send_item(gss_pkg::KIND_VALUE, 32'h7FFF_FFFF);
        send_item(gss_pkg::KIND_VALUE, 32'h8000_0000);
        // A search with extreme values and a tie, then a restart mid-search.
        send_item(gss_pkg::KIND_START, 32'd0);
        send_item(gss_pkg::KIND_VALUE, 32'h8000_0000);
        send_item(gss_pkg::KIND_VALUE, 32'h7FFF_FFFF);
        send_item(gss_pkg::KIND_VALUE, 32'h8000_0000);
        send_item(gss_pkg::KIND_START, 32'hFFFF_FFFF);
        for (int i = 0; i < 16; i++)
            send_item(gss_pkg::KIND_VALUE, i[0] ? -i : i);

        phase_no = 0;
        while (items_sent < ITEM_TARGET)
        begin
            case (phase_no)
                0: ;
                1:
                begin
                    // Full width in reverse order; the width stalls at the end.
                    set_search(32'h7FFF_FFFF, 32'h8000_0000, 32'd0);
                    write_reg(REG_SPARE, 32'hA5A5_5A5A);
                end
                2: set_search(32'd5000, -32'sd5000, 32'd10000);
                3: set_search(32'd0, 32'd1000, 32'hFFFF_FFFF);
                4: set_search(32'h1234_5678, 32'h1234_5678, 32'd0);
                5: set_search(32'h8000_0000, 32'h8000_03E8, 32'd0);
                default: random_setting();
            endcase
            phase_start = items_sent;
            while (items_sent - phase_start < PHASE_ITEMS && items_sent < ITEM_TARGET)
                run_session();
            phase_no++;
        end

        drain();
        if (failures == 0)
            $display("golden_section_search_core_tb: PASS");
        else
            $display("golden_section_search_core_tb: FAIL");
        $finish;
    end

endmodule
